// ===== hdl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam logic [7:0] QUOTE_CHAR     = 8'h22;
  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
  localparam logic [7:0] U_CHAR         = 8'h75;

  localparam logic [2:0] KIND_DATA         = 3'd0;
  localparam logic [2:0] KIND_CLOSED       = 3'd1;
  localparam logic [2:0] KIND_EXPECT_QUOTE = 3'd2;
  localparam logic [2:0] KIND_BAD_UNICODE  = 3'd3;
  localparam logic [2:0] KIND_UNTERMINATED = 3'd4;

  localparam int unsigned MAX_RES = 4;

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_STR  = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    logic [MAX_RES-1:0][7:0]    bytes;
    logic [MAX_RES-1:0][2:0]    kinds;
  } grp_t;

endpackage

// ===== hdl/jsu_decode.sv =====
// Parser state registers and the decoder that turns one source byte into a result group.
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output grp_t       grp
);

  phase_t      ph_r, ph_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        stop_r, stop_nxt;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        is_ws;
  logic [7:0]  esc_val;
  logic [15:0] cp;
  logic [1:0]  k;
  logic [2:0]  last_kind;
  logic        clr;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_val = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_ws = (in_byte == 8'h20) || (in_byte == 8'h09) ||
                 (in_byte == 8'h0A) || (in_byte == 8'h0D);

  always_comb begin
    case (in_byte)
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_val = in_byte;
    endcase
  end

  always_comb begin
    grp      = '0;
    ph_nxt   = ph_r;
    hcnt_nxt = hcnt_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    cp       = acc_r;
    k        = 2'd0;
    case (ph_r)
      PH_WAIT: begin
        if (in_byte == QUOTE_CHAR) begin
          ph_nxt = PH_STR;
          if (in_is_last) begin
            grp.cnt      = 3'd1;
            grp.kinds[0] = KIND_UNTERMINATED;
          end
        end else if (!is_ws || in_is_last) begin
          grp.cnt      = 3'd1;
          grp.kinds[0] = KIND_EXPECT_QUOTE;
        end
      end
      PH_STR: begin
        if (in_byte == QUOTE_CHAR) begin
          grp.cnt      = 3'd1;
          grp.kinds[0] = KIND_CLOSED;
          ph_nxt       = PH_WAIT;
        end else if (in_byte == BACKSLASH_CHAR && !in_is_last) begin
          ph_nxt = PH_ESC;
        end else begin
          grp.bytes[0] = in_byte;
          grp.kinds[0] = KIND_DATA;
          grp.kinds[1] = KIND_UNTERMINATED;
          grp.cnt      = in_is_last ? 3'd2 : 3'd1;
        end
      end
      PH_ESC: begin
        if (in_byte == U_CHAR) begin
          ph_nxt   = PH_HEX;
          hcnt_nxt = 2'd0;
          acc_nxt  = 16'd0;
          stop_nxt = 1'b0;
          if (in_is_last) begin
            grp.cnt      = 3'd1;
            grp.kinds[0] = KIND_BAD_UNICODE;
          end
        end else begin
          ph_nxt       = PH_STR;
          grp.bytes[0] = esc_val;
          grp.kinds[0] = KIND_DATA;
          grp.kinds[1] = KIND_UNTERMINATED;
          grp.cnt      = in_is_last ? 3'd2 : 3'd1;
        end
      end
      PH_HEX: begin
        if (!stop_r && hex_ok) begin
          cp = {acc_r[11:0], hex_val};
        end else begin
          stop_nxt = 1'b1;
        end
        acc_nxt = cp;
        if (hcnt_r == 2'd3) begin
          if (cp < 16'd128) begin
            grp.bytes[0] = cp[7:0];
            k            = 2'd1;
          end else if (cp < 16'd2048) begin
            grp.bytes[0] = {3'b110, cp[10:6]};
            grp.bytes[1] = {2'b10, cp[5:0]};
            k            = 2'd2;
          end else begin
            grp.bytes[0] = {4'b1110, cp[15:12]};
            grp.bytes[1] = {2'b10, cp[11:6]};
            grp.bytes[2] = {2'b10, cp[5:0]};
            k            = 2'd3;
          end
          grp.kinds[k] = KIND_UNTERMINATED;
          grp.cnt      = {1'b0, k} + {2'b00, in_is_last};
          ph_nxt       = PH_STR;
          hcnt_nxt     = 2'd0;
          acc_nxt      = 16'd0;
          stop_nxt     = 1'b0;
        end else begin
          hcnt_nxt = hcnt_r + 2'd1;
          if (in_is_last) begin
            grp.cnt      = 3'd1;
            grp.kinds[0] = KIND_BAD_UNICODE;
          end
        end
      end
      default: begin
        ph_nxt = PH_WAIT;
      end
    endcase
  end

  assign last_kind = grp.kinds[grp.cnt[1:0] - 2'd1];
  assign clr = in_is_last || ((grp.cnt != 3'd0) && (last_kind != KIND_DATA));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_WAIT;
      hcnt_r <= 2'd0;
      acc_r  <= 16'd0;
      stop_r <= 1'b0;
    end else if (in_acc) begin
      if (clr) begin
        ph_r   <= PH_WAIT;
        hcnt_r <= 2'd0;
        acc_r  <= 16'd0;
        stop_r <= 1'b0;
      end else begin
        ph_r   <= ph_nxt;
        hcnt_r <= hcnt_nxt;
        acc_r  <= acc_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

endmodule

// ===== hdl/jsu_emit.sv =====
// Result group register that hands out the group's results one per cycle while out_ready is high.
module jsu_emit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       grp_load,
  input  grp_t       grp,
  output logic       grp_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  grp_t       grp_r;
  logic [2:0] cnt_r;
  logic [1:0] idx_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_last  = out_valid && (idx_r == (cnt_r[1:0] - 2'd1));
  assign out_byte  = grp_r.bytes[idx_r];
  assign out_kind  = grp_r.kinds[idx_r];
  assign pop       = out_valid && out_ready;
  assign grp_free  = !out_valid || (pop && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (grp_load) begin
      cnt_r <= grp.cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      if (out_last) begin
        cnt_r <= 3'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp;
    end
  end

endmodule

// ===== hdl/json_string_unescaper_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// A result is registered and appears in the cycle after the request that causes it.
// Throughput: one request per cycle while each causes at most one result and out_ready is high; a
// request that causes n results (n up to 4) holds the result register until all n have left.
// Reset: synchronous, active low; clears the parser phase, hex state and result group.
module json_string_unescaper_utf8
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  grp_t grp;
  logic grp_free;
  logic in_acc;

  assign in_ready = grp_free;
  assign in_acc   = in_valid && in_ready;

  jsu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .grp        (grp)
  );

  jsu_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_load  (in_acc),
    .grp       (grp),
    .grp_free  (grp_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled with no result pending.");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_last)
    else $error("Non-data result is not the last of its group.");

  a_last_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |-> in_ready)
    else $error("Input not ready while the final result of a group leaves.");

endmodule

// ===== verif/json_string_unescaper_utf8_test.sv =====
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 100ps

module json_string_unescaper_utf8_test
  import jsu_pkg::*;
();

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } src_t;

  typedef struct packed {
    logic [7:0] b;
    logic [2:0] k;
    logic       l;
  } res_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte    = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       out_last;

  src_t       src_q[$];
  res_t       decoded_q[$];
  logic [7:0] doc_q[$];
  src_t       next_src;
  res_t       head_res;

  int unsigned snd_idle     = 28;
  int unsigned rcv_idle     = 82;
  int unsigned queued_cnt   = 0;
  int unsigned mismatch_cnt = 0;

  phase_t      ph    = PH_WAIT;
  logic [1:0]  hcnt  = 2'd0;
  logic [15:0] acc   = 16'h0000;
  logic        hstop = 1'b0;
  logic [7:0]  g_byte [0:MAX_RES-1];
  logic [2:0]  g_kind [0:MAX_RES-1];
  int          g_n;

  json_string_unescaper_utf8 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_kind   (out_kind),
    .out_last   (out_last)
  );

  always #4 clk = ~clk;

  task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatch_cnt++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task clear_decoder();
    ph    = PH_WAIT;
    hcnt  = 2'd0;
    acc   = 16'h0000;
    hstop = 1'b0;
  endtask

  task note_result(input logic [7:0] b, input logic [2:0] k);
    g_byte[g_n] = b;
    g_kind[g_n] = k;
    g_n++;
  endtask

  task unescape_byte(input logic [7:0] b, input logic lst);
    logic [15:0] cp;
    logic [4:0]  nib;
    logic [7:0]  e;
    res_t        r;
    g_n = 0;
    case (ph)
      PH_WAIT: begin
        if (b == QUOTE_CHAR) begin
          ph = PH_STR;
          if (lst) note_result(8'h00, KIND_UNTERMINATED);
        end else if (b inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
          if (lst) note_result(8'h00, KIND_EXPECT_QUOTE);
        end else begin
          note_result(8'h00, KIND_EXPECT_QUOTE);
        end
      end
      PH_STR: begin
        if (b == QUOTE_CHAR) begin
          note_result(8'h00, KIND_CLOSED);
          ph = PH_WAIT;
        end else if (b == BACKSLASH_CHAR && !lst) begin
          ph = PH_ESC;
        end else begin
          note_result(b, KIND_DATA);
          if (lst) note_result(8'h00, KIND_UNTERMINATED);
        end
      end
      PH_ESC: begin
        if (b == U_CHAR) begin
          ph    = PH_HEX;
          hcnt  = 2'd0;
          acc   = 16'h0000;
          hstop = 1'b0;
          if (lst) note_result(8'h00, KIND_BAD_UNICODE);
        end else begin
          case (b)
            "b":     e = 8'h08;
            "f":     e = 8'h0C;
            "n":     e = 8'h0A;
            "r":     e = 8'h0D;
            "t":     e = 8'h09;
            default: e = b;
          endcase
          note_result(e, KIND_DATA);
          ph = PH_STR;
          if (lst) note_result(8'h00, KIND_UNTERMINATED);
        end
      end
      default: begin
        if (b >= "0" && b <= "9") begin
          nib = {1'b0, b[3:0]};
        end else if (b >= "a" && b <= "f") begin
          nib = {1'b0, 4'(b - 8'h57)};
        end else if (b >= "A" && b <= "F") begin
          nib = {1'b0, 4'(b - 8'h37)};
        end else begin
          nib = 5'h10;
        end
        if (!hstop && !nib[4]) begin
          acc = {acc[11:0], nib[3:0]};
        end else begin
          hstop = 1'b1;
        end
        if (hcnt == 2'd3) begin
          cp = acc;
          if (cp < 16'd128) begin
            note_result(cp[7:0], KIND_DATA);
          end else if (cp < 16'd2048) begin
            note_result({3'b110, cp[10:6]}, KIND_DATA);
            note_result({2'b10, cp[5:0]}, KIND_DATA);
          end else begin
            note_result({4'b1110, cp[15:12]}, KIND_DATA);
            note_result({2'b10, cp[11:6]}, KIND_DATA);
            note_result({2'b10, cp[5:0]}, KIND_DATA);
          end
          ph    = PH_STR;
          hcnt  = 2'd0;
          acc   = 16'h0000;
          hstop = 1'b0;
          if (lst) note_result(8'h00, KIND_UNTERMINATED);
        end else begin
          hcnt = hcnt + 2'd1;
          if (lst) note_result(8'h00, KIND_BAD_UNICODE);
        end
      end
    endcase
    if (g_n > 0 && g_kind[g_n-1] != KIND_DATA) clear_decoder();
    if (lst) clear_decoder();
    for (int i = 0; i < g_n; i++) begin
      r.b = g_byte[i];
      r.k = g_kind[i];
      r.l = (i == g_n - 1);
      decoded_q.push_back(r);
    end
  endtask

  task add_src(input logic [7:0] b, input logic l);
    src_t s;
    s.b = b;
    s.l = l;
    src_q.push_back(s);
    queued_cnt++;
  endtask

  task push_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      add_src(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  task gen_doc();
    string      ws_chars  = " \t\n\r";
    string      esc_chars = "\"\\/bfnrt";
    string      hex_chars = "0123456789abcdefABCDEF";
    logic [7:0] c;
    int         sel;
    int         cut;
    doc_q = {};
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) doc_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 2)) doc_q.push_back(ws_chars[$urandom_range(3)]);
        if ($urandom_range(11) == 0) doc_q.push_back(8'($urandom_range(255)));
        doc_q.push_back(QUOTE_CHAR);
        repeat ($urandom_range(0, 6)) begin
          sel = $urandom_range(9);
          if (sel < 4) begin
            c = 8'($urandom_range(255));
            if (c == QUOTE_CHAR || c == BACKSLASH_CHAR) c = c ^ 8'h80;
            doc_q.push_back(c);
          end else if (sel < 7) begin
            doc_q.push_back(BACKSLASH_CHAR);
            if ($urandom_range(3) == 0) begin
              c = 8'($urandom_range(255));
            end else begin
              c = esc_chars[$urandom_range(esc_chars.len() - 1)];
            end
            doc_q.push_back(c);
          end else begin
            doc_q.push_back(BACKSLASH_CHAR);
            doc_q.push_back(U_CHAR);
            for (int i = 0; i < 4; i++) begin
              if ($urandom_range(7) == 0) begin
                c = 8'($urandom_range(255));
              end else if (i < 2 && $urandom_range(2) == 0) begin
                c = "0";
              end else begin
                c = hex_chars[$urandom_range(21)];
              end
              doc_q.push_back(c);
            end
          end
        end
        doc_q.push_back(QUOTE_CHAR);
      end
      repeat ($urandom_range(0, 1)) doc_q.push_back(ws_chars[$urandom_range(3)]);
    end
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(1, doc_q.size());
      while (doc_q.size() > cut) void'(doc_q.pop_back());
    end
    foreach (doc_q[i]) add_src(doc_q[i], i == doc_q.size() - 1);
  endtask

  task drain_all();
    while (src_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) unescape_byte(in_byte, in_is_last);
      if (!in_valid || in_ready) begin
        if (src_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          next_src = src_q.pop_front();
          in_valid   <= 1'b1;
          in_byte    <= next_src.b;
          in_is_last <= next_src.l;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("result with no request pending", out_byte, 8'h00);
        end else begin
          head_res = decoded_q.pop_front();
          if (out_byte !== head_res.b) report_mismatch("out_byte", out_byte, head_res.b);
          if (out_kind !== head_res.k) begin
            report_mismatch("out_kind", {5'b0, out_kind}, {5'b0, head_res.k});
          end
          if (out_last !== head_res.l) begin
            report_mismatch("out_last", {7'b0, out_last}, {7'b0, head_res.l});
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    int unsigned mark;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    push_text("x", 1'b0);
    push_text(" ", 1'b1);
    push_text("\"\\u00e9\\uFFFF\\uz123\\", 1'b1);
    add_src(QUOTE_CHAR, 1'b0);
    add_src(8'h00, 1'b0);
    add_src(8'hFF, 1'b0);
    add_src(QUOTE_CHAR, 1'b1);
    drain_all();
    for (int p = 0; p < 3; p++) begin
      snd_idle = (p == 0) ? 28 : (p == 1) ? 82 : 0;
      rcv_idle = (p == 0) ? 82 : (p == 1) ? 28 : 0;
      mark = queued_cnt;
      while (queued_cnt - mark < 140) gen_doc();
      drain_all();
    end
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/jsu_pkg.sv
hdl/jsu_decode.sv
hdl/jsu_emit.sv
hdl/json_string_unescaper_utf8.sv
verif/json_string_unescaper_utf8_test.sv
